/* sv/wsfp_pkg.sv */
// Shared types and constants for the WebSocket frame parser.
`default_nettype none

package wsfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;
  localparam int unsigned LenW = 16;
  localparam int unsigned KeyW = 32;

  localparam logic [3:0] OpCont = 4'h0;
  localparam logic [3:0] OpText = 4'h1;
  localparam logic [3:0] OpBin = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing = 4'h9;
  localparam logic [3:0] OpPong = 4'hA;

  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXT_HI  = 3'd2,
    PH_EXT_LO  = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef enum logic [KindW-1:0] {
    K_DATA    = 3'd0,
    K_EMPTY   = 3'd1,
    K_PING    = 3'd2,
    K_CLOSE   = 3'd3,
    K_PONG    = 3'd4,
    K_BADLEN  = 3'd5,
    K_UNKNOWN = 3'd6
  } kind_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [ByteW-1:0] data;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

/* sv/wsfp_parse.sv */
// Frame parser state and the single-pass logic that handles one byte.
`default_nettype none

module wsfp_parse (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     fire,
  input  wire logic [wsfp_pkg::ByteW-1:0] rx_byte,
  output wsfp_pkg::res_t                res
);

  wsfp_pkg::phase_t                phase, phase_next;
  logic [wsfp_pkg::LenW-1:0]       remaining, remaining_next;
  logic [wsfp_pkg::KeyW-1:0]       mask_key, mask_key_next;
  logic [1:0]                      key_pos, key_pos_next;
  logic                            is_masked, is_masked_next;
  logic                            deliver, deliver_next;

  logic [3:0]                      op;
  logic [6:0]                      len7;
  logic [wsfp_pkg::LenW-1:0]       rem_dec;
  logic [wsfp_pkg::LenW-1:0]       len_val;
  logic                            len_now;
  logic                            masked_now;
  logic [wsfp_pkg::ByteW-1:0]      key_byte;

  always_comb begin
    case (key_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign op = rx_byte[3:0];
  assign len7 = rx_byte[6:0];
  assign rem_dec = remaining - wsfp_pkg::LenW'(1);

  // This byte completes the length (a key may follow) or the masking key.
  always_comb begin
    len_now = 1'b0;
    masked_now = is_masked;
    len_val = remaining;
    case (phase)
      wsfp_pkg::PH_LEN: begin
        masked_now = rx_byte[7];
        if (len7 != wsfp_pkg::LenExt64 && len7 != wsfp_pkg::LenExt16) begin
          len_val = {{(wsfp_pkg::LenW-7){1'b0}}, len7};
          len_now = 1'b1;
        end
      end
      wsfp_pkg::PH_EXT_LO: begin
        len_val = {remaining[15:8], rx_byte};
        len_now = 1'b1;
      end
      wsfp_pkg::PH_MASK: begin
        if (key_pos == 2'd3) begin
          masked_now = 1'b0;
          len_now = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_next = phase;
    remaining_next = remaining;
    mask_key_next = mask_key;
    key_pos_next = key_pos;
    is_masked_next = is_masked;
    deliver_next = deliver;

    case (phase)
      wsfp_pkg::PH_LEN: begin
        is_masked_next = rx_byte[7];
        if (len7 == wsfp_pkg::LenExt64) begin
          phase_next = wsfp_pkg::PH_HEADER;
        end else if (len7 == wsfp_pkg::LenExt16) begin
          phase_next = wsfp_pkg::PH_EXT_HI;
        end else begin
          remaining_next = len_val;
        end
      end
      wsfp_pkg::PH_EXT_HI: begin
        remaining_next = {rx_byte, 8'h00};
        phase_next = wsfp_pkg::PH_EXT_LO;
      end
      wsfp_pkg::PH_EXT_LO: begin
        remaining_next = len_val;
      end
      wsfp_pkg::PH_MASK: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        key_pos_next = key_pos + 2'd1;
      end
      wsfp_pkg::PH_PAYLOAD: begin
        key_pos_next = key_pos + 2'd1;
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = wsfp_pkg::PH_HEADER;
        end
      end
      default: begin
        if (op inside {wsfp_pkg::OpCont, wsfp_pkg::OpText, wsfp_pkg::OpBin}) begin
          deliver_next = rx_byte[7];
          phase_next = wsfp_pkg::PH_LEN;
        end else if (op inside {wsfp_pkg::OpClose, wsfp_pkg::OpPing, wsfp_pkg::OpPong}) begin
          deliver_next = 1'b0;
          phase_next = wsfp_pkg::PH_LEN;
        end else begin
          phase_next = wsfp_pkg::PH_HEADER;
        end
      end
    endcase

    if (len_now) begin
      key_pos_next = 2'd0;
      if (masked_now) begin
        phase_next = wsfp_pkg::PH_MASK;
      end else if (len_val == '0) begin
        phase_next = wsfp_pkg::PH_HEADER;
      end else begin
        phase_next = wsfp_pkg::PH_PAYLOAD;
      end
    end
  end

  always_comb begin
    res = '0;
    case (phase)
      wsfp_pkg::PH_LEN: begin
        if (len7 == wsfp_pkg::LenExt64) begin
          res.valid = 1'b1;
          res.kind = wsfp_pkg::K_BADLEN;
        end
      end
      wsfp_pkg::PH_EXT_HI, wsfp_pkg::PH_EXT_LO, wsfp_pkg::PH_MASK: begin
      end
      wsfp_pkg::PH_PAYLOAD: begin
        res.valid = deliver;
        res.kind = wsfp_pkg::K_DATA;
        res.data = is_masked ? (rx_byte ^ key_byte) : rx_byte;
        res.last = (rem_dec == '0);
      end
      default: begin
        if (op inside {wsfp_pkg::OpClose, wsfp_pkg::OpPing, wsfp_pkg::OpPong}) begin
          res.valid = 1'b1;
          if (op == wsfp_pkg::OpClose) begin
            res.kind = wsfp_pkg::K_CLOSE;
          end else if (op == wsfp_pkg::OpPing) begin
            res.kind = wsfp_pkg::K_PING;
          end else begin
            res.kind = wsfp_pkg::K_PONG;
          end
        end else if (!(op inside {wsfp_pkg::OpCont, wsfp_pkg::OpText, wsfp_pkg::OpBin})) begin
          res.valid = 1'b1;
          res.kind = wsfp_pkg::K_UNKNOWN;
          res.data = {4'h0, op};
        end
      end
    endcase

    if (len_now && !masked_now && len_val == '0 && deliver) begin
      res.valid = 1'b1;
      res.kind = wsfp_pkg::K_EMPTY;
      res.last = 1'b1;
    end

    if (!fire) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wsfp_pkg::PH_HEADER;
      remaining <= '0;
      mask_key <= '0;
      key_pos <= '0;
      is_masked <= 1'b0;
      deliver <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      remaining <= remaining_next;
      mask_key <= mask_key_next;
      key_pos <= key_pos_next;
      is_masked <= is_masked_next;
      deliver <= deliver_next;
    end
  end

endmodule

`default_nettype wire

/* sv/wsfp_outbuf.sv */
// Result register with a skid slot, so the parser keeps running during a stall until a result fills the skid slot.
`default_nettype none

module wsfp_outbuf (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wsfp_pkg::res_t                  push,
  output logic                            room,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [wsfp_pkg::ByteW-1:0]      m_axis_tdata,
  output logic [wsfp_pkg::KindW-1:0]      m_axis_tuser,
  output logic                            m_axis_tlast
);

  wsfp_pkg::res_t main_q;
  wsfp_pkg::res_t skid_q;

  assign room = !skid_q.valid;
  assign m_axis_tvalid = main_q.valid;
  assign m_axis_tdata = main_q.data;
  assign m_axis_tuser = main_q.kind;
  assign m_axis_tlast = main_q.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_q.valid <= 1'b0;
      skid_q.valid <= 1'b0;
    end else if (!main_q.valid || m_axis_tready) begin
      if (skid_q.valid) begin
        main_q <= skid_q;
        skid_q <= push;
      end else begin
        main_q <= push;
      end
    end else if (push.valid) begin
      skid_q <= push;
    end
  end

endmodule

`default_nettype wire

/* sv/websocket_frame_parser.sv */
// Top level of the WebSocket frame parser: input register, parser, result buffer.
//
//   Port group  Dir  tdata          tuser        tlast
//   s_axis      in   rx_byte[7:0]   -            -
//   m_axis      out  data[7:0]      kind[2:0]    last
//
// One received byte is accepted every cycle while the skid slot is free; its result passes
// through the input register, the skid slot if m_axis stalls, and the result register.
// The parser state advances once per byte between the input register and the
// result register, so there is no extra per-item cost.
// Reset (rst, synchronous) puts the parser back to expecting a frame header.
// A stall on m_axis fills the skid slot, which then holds the input register and
// drops s_axis_tready while the input register holds a byte.
`default_nettype none

module websocket_frame_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [7:0] data
  output logic [2:0]                 m_axis_tuser,   // [2:0] kind
  output logic                       m_axis_tlast
);

  logic                          in_valid;
  logic [wsfp_pkg::ByteW-1:0]    in_byte;
  logic                          advance;
  logic                          room;
  wsfp_pkg::res_t                res;

  assign advance = in_valid && room;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  wsfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .rx_byte (in_byte),
    .res     (res)
  );

  wsfp_outbuf u_outbuf (
    .clk           (clk),
    .rst           (rst),
    .push          (res),
    .room          (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* sv/wsfp_checker.sv */
// Port-level checks for the WebSocket frame parser, bound to the top level.
`default_nettype none

module wsfp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [2:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= wsfp_pkg::K_UNKNOWN))
    else $error("result kind out of range");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tuser == wsfp_pkg::K_DATA || m_axis_tuser == wsfp_pkg::K_EMPTY))
    else $error("last set on a report that is not message data");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != wsfp_pkg::K_DATA &&
     m_axis_tuser != wsfp_pkg::K_UNKNOWN) |-> (m_axis_tdata == 8'h00))
    else $error("report carries nonzero data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled result changed");

  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && !s_axis_tready) |-> m_axis_tvalid)
    else $error("request held back with no result waiting");

endmodule

bind websocket_frame_parser wsfp_checker u_wsfp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* tb/tb_websocket_frame_parser.sv */
// Self-checking testbench for the WebSocket frame parser with random stream stalls.
`timescale 1ns / 100ps

module tb_websocket_frame_parser;

  typedef struct {
    wsfp_pkg::kind_t kind;
    logic [7:0]      data;
    logic            last;
  } ws_result_t;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  websocket_frame_parser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ws_result_t expected_results[$];
  ws_result_t want;
  int         error_count = 0;
  int         n_bytes = 0;
  int         n_results = 0;
  int         gap_pct = 0;
  bit         stall_on = 0;

  wsfp_pkg::phase_t parse_ph = wsfp_pkg::PH_HEADER;
  logic [15:0] bytes_left = '0;
  logic [31:0] key_word = '0;
  logic [1:0]  key_idx = '0;
  logic        frame_masked = 1'b0;
  logic        frame_delivered = 1'b0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string field, input int got, input int exp_val);
    if (error_count < 100) begin
      $display("%0t ns: result %0d, %s is %0h, expected %0h", $time, n_results, field,
               got, exp_val);
    end
    error_count++;
  endtask

  task automatic push_result(input wsfp_pkg::kind_t kind, input logic [7:0] data,
                             input logic last);
    ws_result_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    expected_results.push_back(r);
  endtask

  task automatic start_payload();
    key_idx = '0;
    if (bytes_left == 16'd0) begin
      parse_ph = wsfp_pkg::PH_HEADER;
      if (frame_delivered) begin
        push_result(wsfp_pkg::K_EMPTY, 8'h00, 1'b1);
      end
    end else begin
      parse_ph = wsfp_pkg::PH_PAYLOAD;
    end
  endtask

  task automatic length_known();
    if (frame_masked) begin
      key_idx = '0;
      parse_ph = wsfp_pkg::PH_MASK;
    end else begin
      start_payload();
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [3:0] op;
    logic [7:0] v;
    op = b[3:0];
    case (parse_ph)
      wsfp_pkg::PH_LEN: begin
        frame_masked = b[7];
        if (b[6:0] == wsfp_pkg::LenExt64) begin
          parse_ph = wsfp_pkg::PH_HEADER;
          push_result(wsfp_pkg::K_BADLEN, 8'h00, 1'b0);
        end else if (b[6:0] == wsfp_pkg::LenExt16) begin
          parse_ph = wsfp_pkg::PH_EXT_HI;
        end else begin
          bytes_left = {9'd0, b[6:0]};
          length_known();
        end
      end
      wsfp_pkg::PH_EXT_HI: begin
        bytes_left = {b, 8'h00};
        parse_ph = wsfp_pkg::PH_EXT_LO;
      end
      wsfp_pkg::PH_EXT_LO: begin
        bytes_left[7:0] = b;
        length_known();
      end
      wsfp_pkg::PH_MASK: begin
        key_word = {key_word[23:0], b};
        key_idx = key_idx + 2'd1;
        if (key_idx == 2'd0) begin
          start_payload();
        end
      end
      wsfp_pkg::PH_PAYLOAD: begin
        v = b;
        if (frame_masked) begin
          v = v ^ key_word[31 - 8 * key_idx -: 8];
        end
        key_idx = key_idx + 2'd1;
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) begin
          parse_ph = wsfp_pkg::PH_HEADER;
        end
        if (frame_delivered) begin
          push_result(wsfp_pkg::K_DATA, v, bytes_left == 16'd0);
        end
      end
      default: begin
        if (op inside {wsfp_pkg::OpCont, wsfp_pkg::OpText, wsfp_pkg::OpBin}) begin
          frame_delivered = b[7];
          parse_ph = wsfp_pkg::PH_LEN;
        end else if (op inside {wsfp_pkg::OpClose, wsfp_pkg::OpPing, wsfp_pkg::OpPong}) begin
          frame_delivered = 1'b0;
          parse_ph = wsfp_pkg::PH_LEN;
          if (op == wsfp_pkg::OpClose) begin
            push_result(wsfp_pkg::K_CLOSE, 8'h00, 1'b0);
          end else if (op == wsfp_pkg::OpPing) begin
            push_result(wsfp_pkg::K_PING, 8'h00, 1'b0);
          end else begin
            push_result(wsfp_pkg::K_PONG, 8'h00, 1'b0);
          end
        end else begin
          parse_ph = wsfp_pkg::PH_HEADER;
          push_result(wsfp_pkg::K_UNKNOWN, {4'h0, op}, 1'b0);
        end
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    parse_rx_byte(b);
    n_bytes++;
  endtask

  task automatic send_frame(input logic [7:0] hdr, input logic masked,
                            input logic [15:0] len, input logic use_ext);
    logic [31:0] key;
    key = $urandom;
    send_byte(hdr);
    if (use_ext || len > 16'd125) begin
      send_byte({masked, wsfp_pkg::LenExt16});
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      send_byte({masked, len[6:0]});
    end
    if (masked) begin
      for (int i = 0; i < 4; i++) send_byte(key[31 - 8 * i -: 8]);
    end
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Feeds random bytes until the parser is back at a frame header, keeping
  // any extended length short.
  task automatic settle_parser();
    while (parse_ph != wsfp_pkg::PH_HEADER) begin
      if (parse_ph == wsfp_pkg::PH_EXT_HI) begin
        send_byte(8'($urandom_range(0, 1)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst === 1'b0 && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result kind", m_axis_tuser, 0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.kind) report_mismatch("kind", m_axis_tuser, want.kind);
        if (m_axis_tdata !== want.data) report_mismatch("data", m_axis_tdata, want.data);
        if (m_axis_tlast !== want.last) report_mismatch("last", m_axis_tlast, want.last);
      end
      n_results++;
    end
  end

  initial begin
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_on || $urandom_range(0, 5) != 0) begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 20);
      end else begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 12);
      end
      repeat (n - 1) @(negedge clk);
    end
  end

  task automatic test_data_frames();
    send_byte(8'h81); send_byte(8'h01); send_byte(8'h68);
    send_byte(8'h82); send_byte(8'h82);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'hA5); send_byte(8'h5A);
    send_byte(8'h00); send_byte(8'hFF);
    send_byte(8'h80); send_byte(8'h00);
    send_byte(8'h82); send_byte(8'h7E); send_byte(8'h00); send_byte(8'h01); send_byte(8'hFF);
    send_byte(8'h01); send_byte(8'h01); send_byte(8'h55);
  endtask

  task automatic test_control_frames();
    send_byte(8'h88); send_byte(8'h00);
    send_byte(8'h89); send_byte(8'h00);
    send_byte(8'h8A); send_byte(8'h00);
  endtask

  task automatic test_bad_headers();
    send_byte(8'h82); send_byte(8'hFF);
    send_byte(8'h0F);
    send_byte(8'h8B);
  endtask

  task automatic test_random_traffic(input int count);
    int          start;
    int          pick;
    logic [3:0]  op;
    logic [15:0] len;
    logic        ext;
    start = n_bytes;
    while (n_bytes - start < count) begin
      if (stall_on) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 5;
          default: gap_pct = 25;
        endcase
      end else begin
        gap_pct = 0;
      end
      pick = $urandom_range(0, 99);
      ext = 1'b0;
      len = 16'($urandom_range(0, 12));
      if ($urandom_range(0, 9) == 0) begin
        len = 16'($urandom_range(126, 300));
      end else if ($urandom_range(0, 9) == 0) begin
        ext = 1'b1;
      end
      if (pick < 55) begin
        case ($urandom_range(0, 2))
          0: op = wsfp_pkg::OpCont;
          1: op = wsfp_pkg::OpText;
          default: op = wsfp_pkg::OpBin;
        endcase
        send_frame({$urandom_range(0, 4) != 0, 3'($urandom_range(0, 7)), op},
                   1'($urandom_range(0, 1)), len, ext);
      end else if (pick < 70) begin
        case ($urandom_range(0, 2))
          0: op = wsfp_pkg::OpClose;
          1: op = wsfp_pkg::OpPing;
          default: op = wsfp_pkg::OpPong;
        endcase
        send_frame({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), op},
                   1'($urandom_range(0, 1)), len, ext);
      end else if (pick < 78) begin
        do op = 4'($urandom_range(0, 15));
        while (op inside {wsfp_pkg::OpCont, wsfp_pkg::OpText, wsfp_pkg::OpBin,
                          wsfp_pkg::OpClose, wsfp_pkg::OpPing, wsfp_pkg::OpPong});
        send_byte({4'($urandom_range(0, 15)), op});
      end else if (pick < 84) begin
        send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), wsfp_pkg::OpText});
        send_byte({1'($urandom_range(0, 1)), wsfp_pkg::LenExt64});
      end else if (pick < 92) begin
        send_byte({1'b1, 3'b000, wsfp_pkg::OpBin});
        send_byte(8'($urandom_range(0, 255)));
        settle_parser();
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        settle_parser();
      end
    end
    gap_pct = 0;
  endtask

  task automatic test_long_frame();
    send_frame({1'b1, 3'b000, wsfp_pkg::OpBin}, 1'b1, 16'h0104, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_data_frames();
    test_control_frames();
    test_bad_headers();
    stall_on = 1'b1;
    test_random_traffic(400);
    stall_on = 1'b0;
    test_long_frame();
    test_random_traffic(100);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    for (int i = 0; i < 2000 && expected_results.size() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("results still missing", 0, expected_results.size());
    end

    $display("Sent %0d bytes of data, control, malformed and noise frames, ", n_bytes);
    $display("including one 260-byte masked frame with a 16-bit length; checked %0d results.",
             n_results);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results still expected.", expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* websocket_frame_parser.f */
sv/wsfp_pkg.sv
sv/wsfp_parse.sv
sv/wsfp_outbuf.sv
sv/websocket_frame_parser.sv
sv/wsfp_checker.sv
tb/tb_websocket_frame_parser.sv
